### sv/akg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// akg_pkg: shared types and constants of the glyph pair auto kerning gap block
// Field widths, register indexes, status codes and the transaction structs.
// ----------------------------------------------------------------------------
package akg_pkg;

    localparam int MAX_GLYPH_WIDTH = 32;
    localparam int ROW_W           = 32;
    localparam int WIDTH_W         = 6;
    localparam int COL_W           = 5;
    localparam int GAP_W           = 7;
    localparam int LIMIT_W         = 6;
    localparam int OFFSET_W        = 6;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 6;

    localparam logic [GAP_W-1:0] GAP_ALL_ONES = '1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SPACING_LIMIT  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KERNING_ENABLE = 1'd1;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DISABLED = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0]   left_row;
        logic [WIDTH_W-1:0] left_width;
        logic [ROW_W-1:0]   right_row;
        logic [WIDTH_W-1:0] right_width;
        logic               last_row;
    } akg_in_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] kern_offset;
        logic                status;
    } akg_out_t;

endpackage

`default_nettype wire

### sv/akg_row_gap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// akg_row_gap: gap between two glyph rows
// Empty columns right of the left glyph plus empty columns left of the right.
// ----------------------------------------------------------------------------
module akg_row_gap
    import akg_pkg::*;
(
    input  wire logic [ROW_W-1:0]   left_row,
    input  wire logic [WIDTH_W-1:0] left_width,
    input  wire logic [ROW_W-1:0]   right_row,
    input  wire logic [WIDTH_W-1:0] right_width,
    output logic      [GAP_W-1:0]   row_gap
);

    logic [WIDTH_W-1:0] lw;
    logic [WIDTH_W-1:0] rw;
    logic [ROW_W-1:0]   l_bits;
    logic [ROW_W-1:0]   r_bits;
    logic [COL_W-1:0]   l_top;
    logic [COL_W-1:0]   r_low;
    logic [WIDTH_W-1:0] l_space;
    logic [WIDTH_W-1:0] r_space;

    // Clamp widths to the widest glyph supported
    always_comb begin
        lw = (left_width  > WIDTH_W'(MAX_GLYPH_WIDTH)) ? WIDTH_W'(MAX_GLYPH_WIDTH) : left_width;
        rw = (right_width > WIDTH_W'(MAX_GLYPH_WIDTH)) ? WIDTH_W'(MAX_GLYPH_WIDTH) : right_width;
    end

    // Drop pixels at or beyond each glyph's width
    always_comb begin
        for (int i = 0; i < ROW_W; i++) begin
            l_bits[i] = left_row[i]  & (WIDTH_W'(i) < lw);
            r_bits[i] = right_row[i] & (WIDTH_W'(i) < rw);
        end
    end

    // Rightmost set pixel of the left row, leftmost of the right row
    always_comb begin
        l_top = '0;
        r_low = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (l_bits[i]) l_top = COL_W'(i);
        end
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (r_bits[i]) r_low = COL_W'(i);
        end
    end

    // Empty row counts its full width
    always_comb begin
        l_space = (l_bits == '0) ? lw : WIDTH_W'(lw - WIDTH_W'(1) - {1'b0, l_top});
        r_space = (r_bits == '0) ? rw : {1'b0, r_low};
        // At most 64, so the sum never reaches the all-ones mark
        row_gap = {1'b0, l_space} + {1'b0, r_space};
    end

endmodule

`default_nettype wire

### sv/glyph_pair_auto_kern_gap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_pair_auto_kern_gap: automatic kerning offset of a glyph pair
// Folds per-row gaps into a running minimum and emits a result on the last row.
// ----------------------------------------------------------------------------
// Feed one transaction per bitmap row of a glyph pair: the left and right
// rows with their widths, and last_row on the pair's final row. Rows may
// follow back to back; a row enters an input register, its gap (two priority
// encodes and an add) is folded into the running minimum on the way to the
// result register, so one row per cycle is sustained as long as results are
// taken. Only a last row makes a result transaction, registered in the input
// and then the result register: kern_offset is the minimum row gap clamped
// to spacing_limit (0 means remove the pair) with status 0, or kern_offset 0
// with status 1 when kerning is disabled. The minimum restarts after each
// last row. Write the configuration registers only while no row is in flight.
// ----------------------------------------------------------------------------
module glyph_pair_auto_kern_gap
    import akg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // row input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire akg_in_t               s_data,
    // result output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output akg_out_t                   m_data
);

    logic [LIMIT_W-1:0] spacing_limit_reg;
    logic               kerning_enable_reg;

    logic               in_valid_reg;
    akg_in_t            in_data_reg;
    logic [GAP_W-1:0]   min_gap_reg;
    logic [GAP_W-1:0]   min_gap_next;
    logic               out_valid_reg;
    akg_out_t           out_data_reg;
    akg_out_t           out_data_next;

    logic [GAP_W-1:0]   row_gap;
    logic               out_free;
    logic               proc_fire;
    logic               in_fire;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_limit_reg  <= LIMIT_W'(1);
            kerning_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SPACING_LIMIT:  spacing_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                REG_KERNING_ENABLE: kerning_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Row gap of the held row
    akg_row_gap u_row_gap (
        .left_row    (in_data_reg.left_row),
        .left_width  (in_data_reg.left_width),
        .right_row   (in_data_reg.right_row),
        .right_width (in_data_reg.right_width),
        .row_gap     (row_gap)
    );

    // Advance a held row when it needs no result slot or the slot frees up
    assign out_free  = !out_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && (!in_data_reg.last_row || out_free);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign in_fire   = s_valid && s_ready;

    // Fold the row into the minimum and form the result of a last row
    always_comb begin
        min_gap_next = (row_gap < min_gap_reg) ? row_gap : min_gap_reg;
        if (!kerning_enable_reg) begin
            out_data_next.kern_offset = '0;
            out_data_next.status      = STATUS_DISABLED;
        end else begin
            out_data_next.kern_offset = (min_gap_next > {1'b0, spacing_limit_reg}) ?
                                        spacing_limit_reg : min_gap_next[OFFSET_W-1:0];
            out_data_next.status      = STATUS_OK;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (in_fire) begin
            in_data_reg <= s_data;
        end
    end

    // Running minimum: restart after each last row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_gap_reg <= GAP_ALL_ONES;
        end else if (proc_fire) begin
            min_gap_reg <= in_data_reg.last_row ? GAP_ALL_ONES : min_gap_next;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && in_data_reg.last_row) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc_fire && in_data_reg.last_row) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A last row always restarts the minimum
    a_min_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && in_data_reg.last_row) |=> (min_gap_reg == GAP_ALL_ONES))
        else $error("running minimum not restarted after last row");

    // Minimum is either unset or a reachable row gap
    a_min_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (min_gap_reg == GAP_ALL_ONES) || (min_gap_reg <= GAP_W'(2 * MAX_GLYPH_WIDTH)))
        else $error("running minimum out of range");

    // Disabled kerning reports a zero offset
    a_disabled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_DISABLED) |-> (m_data.kern_offset == '0))
        else $error("disabled result carries a nonzero offset");

endmodule

`default_nettype wire
